// ----- src/rbst_pkg.sv -----
// Shared types and constants for the ray/box slab test pipeline.
// No dependencies.
`default_nettype none
package rbst_pkg;
	localparam int LANES = 6;
	localparam int AXES = 3;
	localparam int QBITS = 33;
	localparam logic signed [31:0] T_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] T_MIN = 32'sh80000000;

	// one division in flight: partial remainder, dividend bits still to
	// shift in, quotient so far, divisor magnitude, sign and overflow
	typedef struct packed {
		logic [31:0] rem;
		logic [32:0] low;
		logic [32:0] q;
		logic [31:0] d;
		logic        neg;
		logic        ovf;
	} lane_t;

	// per axis flags that travel beside the divisions
	typedef struct packed {
		logic [2:0] zmiss;
		logic [2:0] zdir;
	} side_t;
endpackage
`default_nettype wire

// ----- src/rbst_front.sv -----
// Input stage: slab differences, magnitudes and zero-direction checks.
// Depends on rbst_pkg.
`default_nettype none
module rbst_front import rbst_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [31:0] bmin [AXES],
	input  wire logic signed [31:0] bmax [AXES],
	input  wire logic signed [31:0] org  [AXES],
	input  wire logic signed [31:0] dir  [AXES],
	output lane_t                   lane_s1 [LANES],
	output side_t                   side_s1
);
	localparam int NW = QBITS + FRAC_BITS;

	lane_t lane_d [LANES];
	side_t side_d;

	// set up one unsigned division per slab plane
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic signed [32:0] diff;
			logic [32:0] mag;
			logic [NW-1:0] num;
			logic [31:0] dmag;
			logic [31:0] top;
			diff = (l % 2 == 1) ? ({bmax[l/2][31], bmax[l/2]} - {org[l/2][31], org[l/2]})
			                    : ({bmin[l/2][31], bmin[l/2]} - {org[l/2][31], org[l/2]});
			mag = diff[32] ? 33'(-diff) : 33'(diff);
			num = {mag, {FRAC_BITS{1'b0}}};
			dmag = dir[l/2][31] ? 32'(-dir[l/2]) : 32'(dir[l/2]);
			top = {{(32-FRAC_BITS){1'b0}}, num[NW-1:QBITS]};
			lane_d[l].ovf = (top >= dmag);
			lane_d[l].rem = top;
			lane_d[l].low = num[32:0];
			lane_d[l].q = '0;
			lane_d[l].d = dmag;
			lane_d[l].neg = diff[32] ^ dir[l/2][31];
		end
	end

	// zero direction: axis is free inside the slab, a miss outside
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			logic signed [31:0] lo, hi;
			lo = (bmin[a] < bmax[a]) ? bmin[a] : bmax[a];
			hi = (bmin[a] < bmax[a]) ? bmax[a] : bmin[a];
			side_d.zdir[a] = (dir[a] == 32'sd0);
			side_d.zmiss[a] = side_d.zdir[a] && ((org[a] < lo) || (org[a] > hi));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= lane_d;
			side_s1 <= side_d;
		end
	end
endmodule
`default_nettype wire

// ----- src/rbst_div_step.sv -----
// One restoring division step for all six lanes, registered.
// Depends on rbst_pkg.
`default_nettype none
module rbst_div_step import rbst_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  lane_t     lane_i [LANES],
	input  side_t     side_i,
	output lane_t     lane_q [LANES],
	output side_t     side_q
);
	lane_t lane_d [LANES];

	// shift in one dividend bit, subtract when it fits
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [32:0] r;
			logic ge;
			r = {lane_i[l].rem, lane_i[l].low[32]};
			ge = (r >= {1'b0, lane_i[l].d});
			lane_d[l] = lane_i[l];
			lane_d[l].rem = ge ? 32'(r - {1'b0, lane_i[l].d}) : r[31:0];
			lane_d[l].low = {lane_i[l].low[31:0], 1'b0};
			lane_d[l].q = {lane_i[l].q[31:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_d;
			side_q <= side_i;
		end
	end
endmodule
`default_nettype wire

// ----- src/rbst_resolve.sv -----
// Back end: saturate quotients, order slab bounds, intersect, decide hit.
// Depends on rbst_pkg.
`default_nettype none
module rbst_resolve import rbst_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  lane_t     lane_i [LANES],
	input  side_t     side_i,
	output logic      hit_s4
);
	logic signed [31:0] t_s1 [LANES];
	side_t              side_s1;
	logic signed [31:0] lo_s2 [AXES];
	logic signed [31:0] hi_s2 [AXES];
	logic               miss_s2, miss_s3;
	logic signed [31:0] mlo_s3, mhi_s3;

	logic signed [31:0] t_d [LANES];
	logic signed [31:0] lo_d [AXES];
	logic signed [31:0] hi_d [AXES];
	logic signed [31:0] mlo_d, mhi_d;

	// saturate to the signed 32-bit range
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (!lane_i[l].neg) begin
				t_d[l] = (lane_i[l].ovf || lane_i[l].q[32:31] != 2'b00) ? T_MAX
				         : $signed(lane_i[l].q[31:0]);
			end else begin
				t_d[l] = (lane_i[l].ovf || lane_i[l].q > 33'h080000000) ? T_MIN
				         : $signed(32'(-lane_i[l].q));
			end
		end
	end

	// order each pair; a free axis spans the full range
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			if (side_s1.zdir[a]) begin
				lo_d[a] = T_MIN;
				hi_d[a] = T_MAX;
			end else if (t_s1[2*a] > t_s1[2*a+1]) begin
				lo_d[a] = t_s1[2*a+1];
				hi_d[a] = t_s1[2*a];
			end else begin
				lo_d[a] = t_s1[2*a];
				hi_d[a] = t_s1[2*a+1];
			end
		end
	end

	// narrow to the common interval
	always_comb begin
		mlo_d = lo_s2[0];
		mhi_d = hi_s2[0];
		for (int a = 1; a < AXES; a++) begin
			if (lo_s2[a] > mlo_d) mlo_d = lo_s2[a];
			if (hi_s2[a] < mhi_d) mhi_d = hi_s2[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_d;
			side_s1 <= side_i;
			lo_s2 <= lo_d;
			hi_s2 <= hi_d;
			miss_s2 <= |side_s1.zmiss;
			mlo_s3 <= mlo_d;
			mhi_s3 <= mhi_d;
			miss_s3 <= miss_s2;
			hit_s4 <= !miss_s3 && !(mlo_s3 > mhi_s3);
		end
	end
endmodule
`default_nettype wire

// ----- src/ray_box_slab_test_top.sv -----
// Top level of the ray/box slab test: input stage, divider pipeline, back end.
// Depends on rbst_pkg, rbst_front, rbst_div_step, rbst_resolve.
//
// Usage:
//   Input channel item_valid/item_ready carries one box (min and max
//   corners) and one ray (origin, direction), all signed fixed point with
//   FRAC_BITS fraction bits. Output channel hit_valid/hit_ready returns one
//   bit per item: 1 when the ray line crosses the box.
//   The path from transfer in to hit_valid has one setup stage,
//   33 radix-2 divider stages (six dividers side by side, one quotient bit
//   per stage), and four stages of saturation, ordering, intersection and
//   the final compare.
//   One item per cycle unless stalled; the divider chain is fully pipelined.
//   Reset clears all valid bits; the pipeline is empty afterwards.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds; item_ready drops and nothing is lost or repeated.
`default_nettype none
module ray_box_slab_test_top import rbst_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [31:0] box_min_x,
	input  wire logic [31:0] box_min_y,
	input  wire logic [31:0] box_min_z,
	input  wire logic [31:0] box_max_x,
	input  wire logic [31:0] box_max_y,
	input  wire logic [31:0] box_max_z,
	input  wire logic [31:0] origin_x,
	input  wire logic [31:0] origin_y,
	input  wire logic [31:0] origin_z,
	input  wire logic [31:0] dir_x,
	input  wire logic [31:0] dir_y,
	input  wire logic [31:0] dir_z,
	output logic             hit_valid,
	input  wire logic        hit_ready,
	output logic             hit
);
	localparam int DEPTH = 1 + QBITS + 4;

	logic               en;
	logic [DEPTH-1:0]   vld_q;
	logic signed [31:0] bmin [AXES];
	logic signed [31:0] bmax [AXES];
	logic signed [31:0] org  [AXES];
	logic signed [31:0] dir  [AXES];
	lane_t              lane_s [QBITS+1][LANES];
	side_t              side_s [QBITS+1];

	assign bmin = '{$signed(box_min_x), $signed(box_min_y), $signed(box_min_z)};
	assign bmax = '{$signed(box_max_x), $signed(box_max_y), $signed(box_max_z)};
	assign org  = '{$signed(origin_x), $signed(origin_y), $signed(origin_z)};
	assign dir  = '{$signed(dir_x), $signed(dir_y), $signed(dir_z)};

	// advance everything unless a finished result is blocked
	assign en = !vld_q[DEPTH-1] || hit_ready;
	assign item_ready = en;
	assign hit_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], item_valid};
		end
	end

	rbst_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.en      (en),
		.bmin    (bmin),
		.bmax    (bmax),
		.org     (org),
		.dir     (dir),
		.lane_s1 (lane_s[0]),
		.side_s1 (side_s[0])
	);

	for (genvar g = 0; g < QBITS; g++) begin : g_step
		rbst_div_step u_step (
			.clk    (clk),
			.en     (en),
			.lane_i (lane_s[g]),
			.side_i (side_s[g]),
			.lane_q (lane_s[g+1]),
			.side_q (side_s[g+1])
		);
	end

	rbst_resolve u_resolve (
		.clk    (clk),
		.en     (en),
		.lane_i (lane_s[QBITS]),
		.side_i (side_s[QBITS]),
		.hit_s4 (hit)
	);
endmodule
`default_nettype wire

// ----- src/rbst_checker.sv -----
// Port-level checks for the slab test top level, with its bind.
// Depends on ray_box_slab_test_top.
`default_nettype none
module rbst_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_ready,
	input wire logic hit_valid,
	input wire logic hit_ready,
	input wire logic hit
);
	// input side stalls exactly when a result is blocked
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready == (!hit_valid || hit_ready))
		else $error("item_ready does not follow output stall");

	// no result straight out of reset
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !hit_valid)
		else $error("result valid right after reset");

	// a blocked result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !hit_ready |=> hit_valid && $stable(hit))
		else $error("stalled result changed");
endmodule

bind ray_box_slab_test_top rbst_checker u_rbst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_ready (item_ready),
	.hit_valid  (hit_valid),
	.hit_ready  (hit_ready),
	.hit        (hit)
);
`default_nettype wire
